// ----- rtl/isl_pkg.sv -----
// Package for the indexed shift list: sizes, operation and status codes,
// and the control word that the controller broadcasts to the entry cells.
// No dependencies.
package isl_pkg;

  // List capacity and the widths that follow from it.
  localparam int ISL_CAPACITY = 64;
  localparam int ISL_IDX_W    = (ISL_CAPACITY > 1) ? $clog2(ISL_CAPACITY) : 1;
  localparam int ISL_CNT_W    = $clog2(ISL_CAPACITY + 1);

  // Field widths of the input and result words.
  localparam int ISL_OP_W     = 3;
  localparam int ISL_DATA_W   = 32;
  localparam int ISL_POS_W    = 7;
  localparam int ISL_OCNT_W   = 7;
  localparam int ISL_STAT_W   = 2;

  // Width used to compare a position against the entry count.
  localparam int ISL_CMP_W    = (ISL_CNT_W > ISL_POS_W) ? ISL_CNT_W : ISL_POS_W;

  typedef enum logic [ISL_OP_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_PREPEND      = 3'd1,
    OP_INSERT       = 3'd2,
    OP_REMOVE_LAST  = 3'd3,
    OP_REMOVE_FIRST = 3'd4,
    OP_READ         = 3'd5
  } isl_op_t;

  typedef enum logic [ISL_STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } isl_status_t;

  // Control word seen by every cell in the chain.
  typedef struct packed {
    logic                         ins;    // insert: cells above idx take the left neighbor
    logic                         del;    // remove first: every cell takes the right neighbor
    logic [ISL_IDX_W-1:0]         idx;    // insert slot or read slot
    logic signed [ISL_DATA_W-1:0] value;  // value written into the insert slot
  } isl_cell_ctl_t;

  // Per-word outcome from the controller.
  typedef struct packed {
    logic                 read_ok;
    isl_status_t          status;
    logic [ISL_CNT_W-1:0] count;
  } isl_result_t;

endpackage

// ----- rtl/isl_if.sv -----
// Channel interfaces for the indexed shift list: the operation channel and
// the result channel, each with valid/ready and its payload.
// Depends on isl_pkg.
interface isl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [isl_pkg::ISL_OP_W-1:0]          operation;
  logic signed [isl_pkg::ISL_DATA_W-1:0] value;
  logic [isl_pkg::ISL_POS_W-1:0]         position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface isl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [isl_pkg::ISL_DATA_W-1:0] read_value;
  logic [isl_pkg::ISL_OCNT_W-1:0]        entry_count;
  logic [isl_pkg::ISL_STAT_W-1:0]        status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink (input valid, input read_value, input entry_count, input status,
                output ready);
endinterface

// ----- rtl/isl_cell.sv -----
// One entry cell of the shift chain: holds a single list entry and moves it
// toward either neighbor as the broadcast control word directs.
// Depends on isl_pkg.
module isl_cell (
  input  logic                                  clk,
  input  isl_pkg::isl_cell_ctl_t                ctl,
  input  logic                                  fire,
  input  logic [isl_pkg::ISL_IDX_W-1:0]         cell_idx,
  input  logic signed [isl_pkg::ISL_DATA_W-1:0] left_data,
  input  logic signed [isl_pkg::ISL_DATA_W-1:0] right_data,
  output logic signed [isl_pkg::ISL_DATA_W-1:0] data,
  output logic                                  hit
);

  logic signed [isl_pkg::ISL_DATA_W-1:0] data_r;
  logic signed [isl_pkg::ISL_DATA_W-1:0] data_nxt;

  // This cell is the one addressed by the word.
  assign hit = (cell_idx == ctl.idx);

  // Insert opens a gap at idx; remove-first pulls everything down by one.
  always_comb begin
    data_nxt = data_r;
    if (fire && ctl.ins) begin
      if (hit) begin
        data_nxt = ctl.value;
      end else if (cell_idx > ctl.idx) begin
        data_nxt = left_data;
      end
    end else if (fire && ctl.del) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- rtl/isl_ctrl.sv -----
// Controller of the indexed shift list: decodes the operation, checks range,
// full and empty, keeps the entry count and drives the cell control word.
// Depends on isl_pkg.
module isl_ctrl (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  logic [isl_pkg::ISL_OP_W-1:0]          operation,
  input  logic signed [isl_pkg::ISL_DATA_W-1:0] value,
  input  logic [isl_pkg::ISL_POS_W-1:0]         position,
  output isl_pkg::isl_cell_ctl_t                ctl,
  output isl_pkg::isl_result_t                  result
);

  logic [isl_pkg::ISL_CNT_W-1:0] count_r;
  logic [isl_pkg::ISL_CNT_W-1:0] count_nxt;
  logic [isl_pkg::ISL_CMP_W-1:0] cnt_ext;
  logic [isl_pkg::ISL_CMP_W-1:0] pos_ext;
  logic                          full;
  logic                          empty;
  isl_pkg::isl_op_t              op;

  assign op      = isl_pkg::isl_op_t'(operation);
  assign cnt_ext = isl_pkg::ISL_CMP_W'(count_r);
  assign pos_ext = isl_pkg::ISL_CMP_W'(position);
  assign full    = (count_r == isl_pkg::ISL_CNT_W'(isl_pkg::ISL_CAPACITY));
  assign empty   = (count_r == '0);

  // Decode one word into a cell command and its outcome.
  always_comb begin
    ctl.ins        = 1'b0;
    ctl.del        = 1'b0;
    ctl.idx        = position[isl_pkg::ISL_IDX_W-1:0];
    ctl.value      = value;
    result.read_ok = 1'b0;
    result.status  = isl_pkg::ST_OK;
    count_nxt      = count_r;
    unique case (op)
      isl_pkg::OP_APPEND: begin
        ctl.idx = count_r[isl_pkg::ISL_IDX_W-1:0];
        if (full) begin
          result.status = isl_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      isl_pkg::OP_PREPEND: begin
        ctl.idx = '0;
        if (full) begin
          result.status = isl_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      isl_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          result.status = isl_pkg::ST_RANGE;
        end else if (full) begin
          result.status = isl_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      isl_pkg::OP_REMOVE_LAST: begin
        if (empty) begin
          result.status = isl_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      isl_pkg::OP_REMOVE_FIRST: begin
        if (empty) begin
          result.status = isl_pkg::ST_EMPTY;
        end else begin
          ctl.del   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      isl_pkg::OP_READ: begin
        if (pos_ext >= cnt_ext) begin
          result.status = isl_pkg::ST_RANGE;
        end else begin
          result.read_ok = 1'b1;
        end
      end
      default: begin
        // Unused codes change nothing.
      end
    endcase
    result.count = count_nxt;
  end

  // Entry count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/indexed_shift_list.sv -----
// Top level of the indexed shift list: controller, chain of entry cells,
// read select and the result register.
// Depends on isl_pkg, isl_if, isl_ctrl and isl_cell.
//
//   Port     Dir  Handshake     Word carried
//   in_ch    in   valid/ready   operation, value, position
//   out_ch   out  valid/ready   read_value, entry_count, status
//
// All cells shift in parallel at the edge the word is accepted, and the result
// is registered at that same edge and offered in the following cycle.
// Throughput is one word per cycle unless a result stalls; cells and count hold the list.
// Synchronous active-low reset clears the entry count and the result valid.
// A stalled result holds in the output register; a new word is still taken
// in the cycle that the pending result is taken.
module indexed_shift_list (
  input  logic             clk,
  input  logic             rst_n,
  isl_in_if.sink           in_ch,
  isl_out_if.source        out_ch
);

  localparam int N = isl_pkg::ISL_CAPACITY;

  logic                                  fire;
  isl_pkg::isl_cell_ctl_t                ctl;
  isl_pkg::isl_result_t                  result;
  logic signed [isl_pkg::ISL_DATA_W-1:0] cell_data [N];
  logic [N-1:0]                          cell_hit;
  logic signed [isl_pkg::ISL_DATA_W-1:0] rd_sel;

  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  logic signed [isl_pkg::ISL_DATA_W-1:0] rd_val_r;
  logic [isl_pkg::ISL_OCNT_W-1:0]        cnt_r;
  logic [isl_pkg::ISL_STAT_W-1:0]        stat_r;

  // Take a word whenever the result register is free or being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  isl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .operation (in_ch.operation),
    .value     (in_ch.value),
    .position  (in_ch.position),
    .ctl       (ctl),
    .result    (result)
  );

  // Chain of entry cells; the ends see the insert value and themselves.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [isl_pkg::ISL_DATA_W-1:0] left_d;
    logic signed [isl_pkg::ISL_DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = ctl.value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    isl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .fire       (fire),
      .cell_idx   (isl_pkg::ISL_IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit        (cell_hit[i])
    );
  end

  // Read select: AND-OR over the one cell that matches the read slot.
  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < N; k++) begin
      rd_sel = rd_sel | (cell_data[k] & {isl_pkg::ISL_DATA_W{cell_hit[k]}});
    end
  end

  // Result valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      rd_val_r <= result.read_ok ? rd_sel : '0;
      cnt_r    <= isl_pkg::ISL_OCNT_W'(result.count);
      stat_r   <= result.status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = rd_val_r;
  assign out_ch.entry_count = cnt_r;
  assign out_ch.status      = stat_r;

endmodule
